/* rtl/core/msqe_pkg.sv */
// ----------------------------------------------------------------------------
// msqe_pkg
// Shared types and constants for the stack and queue engine.
// ----------------------------------------------------------------------------
package msqe_pkg;

  localparam int unsigned CfgW  = 5;
  localparam int unsigned DataW = 32;

  typedef enum logic [3:0] {
    OP_NEW_S   = 4'd0,
    OP_DEL_S   = 4'd1,
    OP_PUSH    = 4'd2,
    OP_POP     = 4'd3,
    OP_DUMP_S  = 4'd4,
    OP_NEW_Q   = 4'd5,
    OP_DEL_Q   = 4'd6,
    OP_ENQ     = 4'd7,
    OP_DEQ     = 4'd8,
    OP_DUMP_Q  = 4'd9,
    OP_MV_QQ   = 4'd10,
    OP_MV_SQ   = 4'd11,
    OP_MV_QS   = 4'd12,
    OP_MV_SS   = 4'd13,
    OP_RSVD_14 = 4'd14,
    OP_RSVD_15 = 4'd15
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_BAD   = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    REG_STACK_COUNT = 2'd0,
    REG_QUEUE_COUNT = 2'd1,
    REG_STACK_CAP   = 2'd2,
    REG_QUEUE_CAP   = 2'd3
  } reg_e;

  typedef struct packed {
    logic [3:0]              opcode;
    logic [3:0]              src_index;
    logic [3:0]              dst_index;
    logic signed [DataW-1:0] value;
  } in_word_t;

  typedef struct packed {
    logic [1:0]              status;
    logic                    data_valid;
    logic signed [DataW-1:0] data;
    logic                    last;
  } out_word_t;

  // read and write request to one element memory
  typedef struct packed {
    logic             re;
    logic             we;
    logic [11:0]      addr;
    logic [DataW-1:0] wdata;
  } mem_req_t;

endpackage

/* rtl/core/msqe_mem.sv */
// ----------------------------------------------------------------------------
// msqe_mem
// Element store: one write and one read per cycle, registered read data.
// ----------------------------------------------------------------------------
module msqe_mem #(
  parameter int unsigned Entries = 256,
  parameter int unsigned AddrW   = 8
) (
  input  logic                      clk_i,
  input  msqe_pkg::mem_req_t        req_i,
  output logic [msqe_pkg::DataW-1:0] rdata_o
);
  import msqe_pkg::*;

  logic [DataW-1:0] mem_q [Entries];

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.addr[AddrW-1:0]] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_o <= mem_q[req_i.addr[AddrW-1:0]];
    end
  end

endmodule

/* rtl/core/multi_stack_queue_engine_top.sv */
// ----------------------------------------------------------------------------
// multi_stack_queue_engine_top
// Bank of bounded stacks and FIFO queues with move and dump operations.
// Create/delete/push/enqueue and failures answer from S_EXEC; pop/dequeue add S_RD; move adds S_RD and S_PUSH.
// Dump: one element per cycle from the store.
// busy is high from accept until the last word; one item at a time.
// Reset clears all exists flags, fill counts and heads; store is undefined.
// Results are strobed for one cycle; the receiver cannot stall.
// ----------------------------------------------------------------------------
module multi_stack_queue_engine_top #(
  parameter int unsigned NUM_STRUCTS = 16,
  parameter int unsigned DEPTH       = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  msqe_pkg::in_word_t        in_word_i,
  output logic                      out_valid_o,
  output msqe_pkg::out_word_t       out_word_o,
  input  logic                      cfg_we_i,
  input  logic [1:0]                cfg_idx_i,
  input  logic [msqe_pkg::CfgW-1:0] cfg_wdata_i
);
  import msqe_pkg::*;

  localparam int unsigned SW  = (NUM_STRUCTS > 1) ? $clog2(NUM_STRUCTS) : 1;
  localparam int unsigned DW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned FW  = $clog2(DEPTH + 1);
  localparam int unsigned XW  = FW + 1;
  localparam int unsigned AW  = SW + DW;
  localparam int unsigned CapLim = (DEPTH < 16) ? DEPTH : 16;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_EXEC  = 6'b000010,
    S_RD    = 6'b000100,
    S_PUSH  = 6'b001000,
    S_DUMP  = 6'b010000,
    S_DONE  = 6'b100000
  } state_e;

  state_e state_q, state_d;
  in_word_t cmd_q;
  logic [CfgW-1:0] s_cnt_q, q_cnt_q, s_cap_q, q_cap_q;
  logic [NUM_STRUCTS-1:0] s_ex_q, q_ex_q;
  logic [FW-1:0] s_fill_q [NUM_STRUCTS];
  logic [FW-1:0] q_fill_q [NUM_STRUCTS];
  logic [DW-1:0] q_head_q [NUM_STRUCTS];
  logic [FW-1:0] cnt_q, n_q;
  logic [DataW-1:0] item_q;
  logic pend_q, pend_last_q;

  mem_req_t sreq, qreq;
  logic [DataW-1:0] s_rdata, q_rdata;

  msqe_mem #(.Entries(2 ** AW), .AddrW(AW)) u_smem (
    .clk_i(clk_i), .req_i(sreq), .rdata_o(s_rdata));
  msqe_mem #(.Entries(2 ** AW), .AddrW(AW)) u_qmem (
    .clk_i(clk_i), .req_i(qreq), .rdata_o(q_rdata));

  op_e op;
  logic from_q, to_q;
  logic [SW-1:0] si, di;
  logic src_rng_s, src_rng_q, dst_rng_s, dst_rng_q;
  logic src_ok, dst_ok;
  logic [FW-1:0] src_fill, dst_fill, s_capx, q_capx, dst_cap;
  logic [DW-1:0] src_head, dst_head;
  logic [FW-1:0] eff_s, eff_q;

  function automatic logic [FW-1:0] eff_cap(input logic [CfgW-1:0] c);
    if (32'(c) > CapLim) eff_cap = FW'(CapLim);
    else eff_cap = FW'(c);
  endfunction

  // slot index modulo DEPTH
  function automatic logic [DW-1:0] wrap_add(input logic [DW-1:0] a,
                                             input logic [FW-1:0] b);
    logic [XW-1:0] s;
    s = XW'(a) + XW'(b);
    if (s >= XW'(DEPTH)) s = s - XW'(DEPTH);
    return DW'(s);
  endfunction

  always_comb begin
    op      = op_e'(cmd_q.opcode);
    from_q  = op inside {OP_MV_QQ, OP_MV_QS, OP_NEW_Q, OP_DEL_Q, OP_ENQ, OP_DEQ,
                         OP_DUMP_Q};
    to_q    = op inside {OP_MV_QQ, OP_MV_SQ};
    si      = SW'(cmd_q.src_index);
    di      = SW'(cmd_q.dst_index);
    src_rng_s = (5'(cmd_q.src_index) < s_cnt_q) && (32'(cmd_q.src_index) < NUM_STRUCTS);
    src_rng_q = (5'(cmd_q.src_index) < q_cnt_q) && (32'(cmd_q.src_index) < NUM_STRUCTS);
    dst_rng_s = (5'(cmd_q.dst_index) < s_cnt_q) && (32'(cmd_q.dst_index) < NUM_STRUCTS);
    dst_rng_q = (5'(cmd_q.dst_index) < q_cnt_q) && (32'(cmd_q.dst_index) < NUM_STRUCTS);
    src_ok  = from_q ? (src_rng_q && q_ex_q[si]) : (src_rng_s && s_ex_q[si]);
    dst_ok  = to_q ? (dst_rng_q && q_ex_q[di]) : (dst_rng_s && s_ex_q[di]);
    src_fill = from_q ? q_fill_q[si] : s_fill_q[si];
    dst_fill = to_q ? q_fill_q[di] : s_fill_q[di];
    src_head = q_head_q[si];
    dst_head = q_head_q[di];
    eff_s   = eff_cap(s_cap_q);
    eff_q   = eff_cap(q_cap_q);
    s_capx  = eff_s;
    q_capx  = eff_q;
    dst_cap = to_q ? q_capx : s_capx;
  end

  // next-state and memory requests
  logic [1:0] st_d;
  logic       ov_d, dv_d, last_d;
  logic [DataW-1:0] data_d;
  logic [FW-1:0] cnt_d, n_d;
  logic [DataW-1:0] item_d;
  logic pend_d, pend_last_d;
  logic [DW-1:0] pos;

  always_comb begin
    state_d = state_q;
    cnt_d = cnt_q; n_d = n_q; item_d = item_q;
    pend_d = 1'b0; pend_last_d = 1'b0;
    ov_d = 1'b0; st_d = ST_OK; dv_d = 1'b0; data_d = '0; last_d = 1'b1;
    sreq = '0; qreq = '0;
    pos = '0;
    case (state_q)
      S_IDLE: begin
        if (start) state_d = S_EXEC;
      end
      S_EXEC: begin
        state_d = S_IDLE;
        ov_d = 1'b1;
        case (op)
          OP_NEW_S, OP_NEW_Q: st_d = (from_q ? src_rng_q : src_rng_s) ? ST_OK : ST_BAD;
          OP_DEL_S, OP_DEL_Q: st_d = src_ok ? ST_OK : ST_BAD;
          OP_PUSH, OP_ENQ: begin
            if (!src_ok) st_d = ST_BAD;
            else if (src_fill >= (from_q ? q_capx : s_capx)) st_d = ST_FULL;
            else begin
              st_d = ST_OK;
              pos = from_q ? wrap_add(src_head, src_fill) : DW'(src_fill);
              if (from_q) begin
                qreq.we = 1'b1; qreq.addr = 12'({si, pos}); qreq.wdata = cmd_q.value;
              end else begin
                sreq.we = 1'b1; sreq.addr = 12'({si, pos}); sreq.wdata = cmd_q.value;
              end
            end
          end
          OP_POP, OP_DEQ, OP_MV_QQ, OP_MV_SQ, OP_MV_QS, OP_MV_SS: begin
            if (!src_ok) st_d = ST_BAD;
            else if (src_fill == '0) st_d = ST_EMPTY;
            else begin
              ov_d = 1'b0;
              state_d = S_RD;
              pos = from_q ? src_head : DW'(src_fill - 1'b1);
              if (from_q) begin
                qreq.re = 1'b1; qreq.addr = 12'({si, pos});
              end else begin
                sreq.re = 1'b1; sreq.addr = 12'({si, pos});
              end
            end
          end
          OP_DUMP_S, OP_DUMP_Q: begin
            if (!src_ok) st_d = ST_BAD;
            else if (src_fill == '0) st_d = ST_EMPTY;
            else begin
              ov_d = 1'b0;
              state_d = S_DUMP;
              n_d = src_fill;
              cnt_d = '0;
            end
          end
          default: st_d = ST_BAD;
        endcase
      end
      S_RD: begin
        item_d = from_q ? q_rdata : s_rdata;
        if (op == OP_POP || op == OP_DEQ) begin
          ov_d = 1'b1; dv_d = 1'b1; data_d = item_d; state_d = S_IDLE;
        end else begin
          state_d = S_PUSH;
        end
      end
      S_PUSH: begin
        ov_d = 1'b1; dv_d = 1'b1; data_d = item_q; state_d = S_IDLE;
        if (!dst_ok) st_d = ST_BAD;
        else if (dst_fill >= dst_cap) st_d = ST_FULL;
        else begin
          st_d = ST_OK;
          pos = to_q ? wrap_add(dst_head, dst_fill) : DW'(dst_fill);
          if (to_q) begin
            qreq.we = 1'b1; qreq.addr = 12'({di, pos}); qreq.wdata = item_q;
          end else begin
            sreq.we = 1'b1; sreq.addr = 12'({di, pos}); sreq.wdata = item_q;
          end
        end
      end
      S_DUMP: begin
        pend_d = 1'b1;
        pend_last_d = (cnt_q == n_q - 1'b1);
        pos = from_q ? wrap_add(src_head, n_q - 1'b1 - cnt_q) : DW'(cnt_q);
        if (from_q) begin
          qreq.re = 1'b1; qreq.addr = 12'({si, pos});
        end else begin
          sreq.re = 1'b1; sreq.addr = 12'({si, pos});
        end
        cnt_d = cnt_q + 1'b1;
        if (pend_last_d) state_d = S_DONE;
      end
      S_DONE: begin
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
    if (pend_q) begin
      ov_d = 1'b1; dv_d = 1'b1; st_d = ST_OK; last_d = pend_last_q;
      data_d = from_q ? q_rdata : s_rdata;
    end
  end

  assign busy = (state_q != S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      s_cnt_q <= 5'd10; q_cnt_q <= 5'd10; s_cap_q <= 5'd10; q_cap_q <= 5'd10;
      s_ex_q <= '0; q_ex_q <= '0;
      for (int i = 0; i < NUM_STRUCTS; i++) begin
        s_fill_q[i] <= '0; q_fill_q[i] <= '0; q_head_q[i] <= '0;
      end
      pend_q <= 1'b0; pend_last_q <= 1'b0;
      out_valid_o <= 1'b0;
      cnt_q <= '0; n_q <= '0;
    end else begin
      state_q <= state_d;
      pend_q <= pend_d; pend_last_q <= pend_last_d;
      cnt_q <= cnt_d; n_q <= n_d;
      out_valid_o <= ov_d;
      if (cfg_we_i) begin
        case (reg_e'(cfg_idx_i))
          REG_STACK_COUNT: s_cnt_q <= cfg_wdata_i;
          REG_QUEUE_COUNT: q_cnt_q <= cfg_wdata_i;
          REG_STACK_CAP:   s_cap_q <= cfg_wdata_i;
          REG_QUEUE_CAP:   q_cap_q <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (state_q == S_EXEC) begin
        case (op)
          OP_NEW_S: if (src_rng_s) begin s_ex_q[si] <= 1'b1; s_fill_q[si] <= '0; end
          OP_NEW_Q: if (src_rng_q) begin
            q_ex_q[si] <= 1'b1; q_fill_q[si] <= '0; q_head_q[si] <= '0;
          end
          OP_DEL_S: if (src_ok) begin s_ex_q[si] <= 1'b0; s_fill_q[si] <= '0; end
          OP_DEL_Q: if (src_ok) begin
            q_ex_q[si] <= 1'b0; q_fill_q[si] <= '0; q_head_q[si] <= '0;
          end
          OP_PUSH: if (sreq.we) s_fill_q[si] <= s_fill_q[si] + 1'b1;
          OP_ENQ:  if (qreq.we) q_fill_q[si] <= q_fill_q[si] + 1'b1;
          default: ;
        endcase
        if (state_d == S_RD) begin
          if (from_q) begin
            q_fill_q[si] <= q_fill_q[si] - 1'b1;
            q_head_q[si] <= wrap_add(q_head_q[si], FW'(1));
          end else begin
            s_fill_q[si] <= s_fill_q[si] - 1'b1;
          end
        end
      end
      if (state_q == S_PUSH) begin
        if (sreq.we) s_fill_q[di] <= s_fill_q[di] + 1'b1;
        if (qreq.we) q_fill_q[di] <= q_fill_q[di] + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && start) cmd_q <= in_word_i;
    item_q <= item_d;
    out_word_o.status     <= st_d;
    out_word_o.data_valid <= dv_d;
    out_word_o.data       <= data_d;
    out_word_o.last       <= last_d;
  end

  a_no_out_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && !$past(busy)) |-> !out_valid_o)
    else $error("result strobe while idle");
  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_word_o.last) |-> !$past(pend_q) || !busy)
    else $error("last word while still dumping");
  a_mem_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(sreq.we && sreq.re) && !(qreq.we && qreq.re))
    else $error("read and write in same cycle");

endmodule

/* tb/sv/multi_stack_queue_engine_top_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// multi_stack_queue_engine_top_tb
// Drives random and directed commands into the stack and queue engine, across
// several register settings, and checks every strobed result word against a
// scoreboard that tracks the stacks and queues itself.
// ----------------------------------------------------------------------------
module multi_stack_queue_engine_top_tb;
  import msqe_pkg::*;

  class stack_queue_board;
    int unsigned stack_cnt, queue_cnt, stack_cap, queue_cap;
    bit          s_ex[16];
    int unsigned s_fill[16];
    logic [31:0] s_mem[16][16];
    bit          q_ex[16];
    int unsigned q_head[16];
    int unsigned q_fill[16];
    logic [31:0] q_mem[16][16];
    out_word_t   pending[$];
    int unsigned mismatches;

    function void reset_state();
      stack_cnt = 10; queue_cnt = 10; stack_cap = 10; queue_cap = 10;
      mismatches = 0;
      for (int i = 0; i < 16; i++) begin
        s_ex[i] = 0; s_fill[i] = 0; q_ex[i] = 0; q_head[i] = 0; q_fill[i] = 0;
      end
    endfunction

    function void set_reg(reg_e r, int unsigned v);
      case (r)
        REG_STACK_COUNT: stack_cnt = v;
        REG_QUEUE_COUNT: queue_cnt = v;
        REG_STACK_CAP:   stack_cap = v;
        default:         queue_cap = v;
      endcase
    endfunction

    function int unsigned cap_of(int unsigned r);
      return (r > 16) ? 16 : r;
    endfunction

    function bit s_ok(int unsigned i);
      return i < stack_cnt && i < 16 && s_ex[i];
    endfunction

    function bit q_ok(int unsigned i);
      return i < queue_cnt && i < 16 && q_ex[i];
    endfunction

    function void add(status_e st, bit dv, logic [31:0] d, bit lst);
      out_word_t o;
      o.status = st; o.data_valid = dv; o.data = d; o.last = lst;
      pending = {pending, o};
    endfunction

    function status_e s_push(int unsigned i, logic [31:0] v);
      if (!s_ok(i)) return ST_BAD;
      if (s_fill[i] >= cap_of(stack_cap)) return ST_FULL;
      s_mem[i][s_fill[i]] = v;
      s_fill[i]++;
      return ST_OK;
    endfunction

    function status_e s_pop(int unsigned i, output logic [31:0] v);
      v = '0;
      if (!s_ok(i)) return ST_BAD;
      if (s_fill[i] == 0) return ST_EMPTY;
      s_fill[i]--;
      v = s_mem[i][s_fill[i]];
      return ST_OK;
    endfunction

    function status_e q_push(int unsigned i, logic [31:0] v);
      if (!q_ok(i)) return ST_BAD;
      if (q_fill[i] >= cap_of(queue_cap)) return ST_FULL;
      q_mem[i][(q_head[i] + q_fill[i]) % 16] = v;
      q_fill[i]++;
      return ST_OK;
    endfunction

    function status_e q_pop(int unsigned i, output logic [31:0] v);
      v = '0;
      if (!q_ok(i)) return ST_BAD;
      if (q_fill[i] == 0) return ST_EMPTY;
      v = q_mem[i][q_head[i]];
      q_head[i] = (q_head[i] + 1) % 16;
      q_fill[i]--;
      return ST_OK;
    endfunction

    function void note_input(in_word_t w);
      int unsigned s, d, n;
      logic [31:0] item;
      status_e     st;
      op_e         op;
      s = 32'(w.src_index); d = 32'(w.dst_index);
      op = op_e'(w.opcode);
      case (op)
        OP_NEW_S: begin
          if (s < stack_cnt) begin
            s_ex[s] = 1; s_fill[s] = 0; add(ST_OK, 0, '0, 1);
          end else add(ST_BAD, 0, '0, 1);
        end
        OP_NEW_Q: begin
          if (s < queue_cnt) begin
            q_ex[s] = 1; q_fill[s] = 0; q_head[s] = 0; add(ST_OK, 0, '0, 1);
          end else add(ST_BAD, 0, '0, 1);
        end
        OP_DEL_S: begin
          if (s_ok(s)) begin
            s_ex[s] = 0; s_fill[s] = 0; add(ST_OK, 0, '0, 1);
          end else add(ST_BAD, 0, '0, 1);
        end
        OP_DEL_Q: begin
          if (q_ok(s)) begin
            q_ex[s] = 0; q_fill[s] = 0; q_head[s] = 0; add(ST_OK, 0, '0, 1);
          end else add(ST_BAD, 0, '0, 1);
        end
        OP_PUSH: add(s_push(s, w.value), 0, '0, 1);
        OP_ENQ:  add(q_push(s, w.value), 0, '0, 1);
        OP_POP, OP_DEQ: begin
          st = (op == OP_POP) ? s_pop(s, item) : q_pop(s, item);
          if (st == ST_OK) add(ST_OK, 1, item, 1);
          else add(st, 0, '0, 1);
        end
        OP_DUMP_S: begin
          if (!s_ok(s)) add(ST_BAD, 0, '0, 1);
          else if (s_fill[s] == 0) add(ST_EMPTY, 0, '0, 1);
          else begin
            n = s_fill[s];
            for (int i = 0; i < n; i++) add(ST_OK, 1, s_mem[s][i], i + 1 == n);
          end
        end
        OP_DUMP_Q: begin
          if (!q_ok(s)) add(ST_BAD, 0, '0, 1);
          else if (q_fill[s] == 0) add(ST_EMPTY, 0, '0, 1);
          else begin
            n = q_fill[s];
            for (int i = 0; i < n; i++)
              add(ST_OK, 1, q_mem[s][(q_head[s] + n - 1 - i) % 16], i + 1 == n);
          end
        end
        OP_MV_QQ, OP_MV_SQ, OP_MV_QS, OP_MV_SS: begin
          st = (op == OP_MV_QQ || op == OP_MV_QS) ? q_pop(s, item) : s_pop(s, item);
          if (st != ST_OK) add(st, 0, '0, 1);
          else begin
            st = (op == OP_MV_QQ || op == OP_MV_SQ) ? q_push(d, item) : s_push(d, item);
            add(st, 1, item, 1);
          end
        end
        default: add(ST_BAD, 0, '0, 1);
      endcase
    endfunction

    function void check_result(out_word_t o);
      out_word_t e;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word: %h", o);
        return;
      end
      e = pending[0];
      pending.delete(0);
      if (o.status !== e.status || o.data_valid !== e.data_valid ||
          o.data !== e.data || o.last !== e.last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp st=%0d dv=%0d d=%h l=%0d act st=%0d dv=%0d d=%h l=%0d",
                   e.status, e.data_valid, e.data, e.last,
                   o.status, o.data_valid, o.data, o.last);
      end
    endfunction
  endclass

  logic                clk_i = 0;
  logic                rst_ni = 0;
  logic                start = 0;
  logic                busy;
  in_word_t            in_word_i = '0;
  logic                out_valid_o;
  out_word_t           out_word_o;
  logic                cfg_we_i = 0;
  logic [1:0]          cfg_idx_i = '0;
  logic [CfgW-1:0]     cfg_wdata_i = '0;

  stack_queue_board board;
  int unsigned      cycles = 0;
  int unsigned      burst_left = 0;

  multi_stack_queue_engine_top DUT (
    .clk_i, .rst_ni, .start, .busy, .in_word_i, .out_valid_o, .out_word_o,
    .cfg_we_i, .cfg_idx_i, .cfg_wdata_i
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("multi_stack_queue_engine_top_tb failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o) board.check_result(out_word_o);
  end

  task automatic send_word(in_word_t w);
    start <= 1'b1;
    in_word_i <= w;
    do @(posedge clk_i); while (busy);
    board.note_input(w);
    // bursty sender
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if ($urandom_range(0, 3) != 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end
    end else burst_left--;
  endtask

  task automatic cmd(op_e op, int unsigned s, int unsigned d, logic [31:0] v);
    in_word_t w;
    w.opcode = op; w.src_index = 4'(s); w.dst_index = 4'(d); w.value = v;
    send_word(w);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (24) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_e r, int unsigned v);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= r;
    cfg_wdata_i <= CfgW'(v);
    @(posedge clk_i);
    board.set_reg(r, v);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic configure(int unsigned sc, int unsigned qc, int unsigned scap,
                           int unsigned qcap);
    drain();
    write_reg(REG_STACK_COUNT, sc);
    write_reg(REG_QUEUE_COUNT, qc);
    write_reg(REG_STACK_CAP, scap);
    write_reg(REG_QUEUE_CAP, qcap);
  endtask

  task automatic random_items(int unsigned n);
    in_word_t    w;
    int unsigned lim;
    for (int k = 0; k < n; k++) begin
      w.value = $urandom();
      w.dst_index = 4'($urandom_range(0, 15));
      if ($urandom_range(0, 9) == 0) begin
        w.opcode = 4'($urandom_range(0, 15));
        w.src_index = 4'($urandom_range(0, 15));
      end else begin
        w.opcode = 4'($urandom_range(0, 13));
        lim = (board.stack_cnt < board.queue_cnt) ? board.stack_cnt : board.queue_cnt;
        w.src_index = 4'($urandom_range(0, (lim > 4 ? 4 : lim) - 1));
        if ($urandom_range(0, 3) != 0) w.dst_index = 4'($urandom_range(0, 3));
        if ($urandom_range(0, 4) == 0) w.src_index = 4'($urandom_range(0, 15));
        // weight toward filling
        if ($urandom_range(0, 2) == 0) w.opcode = $urandom_range(0, 1) ? OP_PUSH : OP_ENQ;
      end
      send_word(w);
    end
  endtask

  initial begin
    board = new();
    board.reset_state();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    cmd(OP_PUSH, 0, 0, 32'h1);
    cmd(OP_NEW_S, 0, 0, 0);
    cmd(OP_NEW_Q, 0, 0, 0);
    cmd(OP_NEW_S, 15, 0, 0);
    cmd(OP_DUMP_S, 0, 0, 0);
    cmd(OP_POP, 0, 0, 0);
    cmd(OP_PUSH, 0, 0, 32'h7fffffff);
    cmd(OP_PUSH, 0, 0, 32'h80000000);
    cmd(OP_PUSH, 0, 0, 32'hffffffff);
    cmd(OP_DUMP_S, 0, 0, 0);
    cmd(OP_POP, 0, 0, 0);
    cmd(OP_ENQ, 0, 0, 32'h0);
    cmd(OP_ENQ, 0, 0, 32'h55aa55aa);
    cmd(OP_ENQ, 0, 0, 32'haa55aa55);
    cmd(OP_DUMP_Q, 0, 0, 0);
    cmd(OP_DEQ, 0, 0, 0);
    cmd(OP_MV_SQ, 0, 0, 0);
    cmd(OP_MV_QS, 0, 0, 0);
    cmd(OP_MV_SS, 0, 0, 0);
    cmd(OP_MV_QQ, 0, 0, 0);
    cmd(OP_MV_QS, 0, 9, 0);
    cmd(OP_MV_SS, 5, 0, 0);
    cmd(OP_RSVD_14, 0, 0, 0);
    cmd(OP_RSVD_15, 15, 15, 32'hffffffff);
    cmd(OP_DEL_S, 0, 0, 0);
    cmd(OP_DEL_S, 0, 0, 0);
    cmd(OP_DEL_Q, 0, 0, 0);
    random_items(10);

    configure(16, 16, 16, 16);
    for (int i = 0; i < 2; i++) cmd(OP_PUSH, 15, 0, $urandom());
    cmd(OP_NEW_S, 15, 0, 0);
    cmd(OP_NEW_Q, 15, 0, 0);
    for (int i = 0; i < 17; i++) cmd(OP_PUSH, 15, 0, $urandom());
    for (int i = 0; i < 17; i++) cmd(OP_ENQ, 15, 0, $urandom());
    cmd(OP_DUMP_S, 15, 0, 0);
    cmd(OP_DUMP_Q, 15, 0, 0);
    random_items(12);

    configure(1, 1, 1, 1);
    cmd(OP_NEW_S, 0, 0, 0);
    cmd(OP_NEW_Q, 0, 0, 0);
    cmd(OP_PUSH, 0, 0, 32'h1234);
    cmd(OP_PUSH, 0, 0, 32'h5678);
    cmd(OP_MV_SQ, 0, 0, 0);
    random_items(8);

    configure(5, 7, 3, 16);
    random_items(10);

    drain();
    if (board.mismatches == 0 && board.pending.size() == 0) begin
      $display("multi_stack_queue_engine_top_tb passed");
    end else begin
      $display("multi_stack_queue_engine_top_tb failed");
    end
    $finish;
  end

endmodule
